// File: sv/rmg_pkg.sv
`timescale 1ns / 1ps
package rmg_pkg;

    localparam int ATAN_LEN = 24;
    localparam int AW = 35;
    localparam int XW = 33;

    localparam logic signed [AW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [AW-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;
    localparam logic signed [16:0]   ONE_Q14     = 17'sd16384;

    localparam logic FUNC_AXIS  = 1'b0;
    localparam logic FUNC_EULER = 1'b1;

    typedef logic signed [15:0] t_q14;

    typedef logic signed [XW-1:0] t_cval;
    typedef logic signed [AW-1:0] t_aval;

    function automatic t_aval atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:  atan_q30 = 35'sd843314856;
            5'd1:  atan_q30 = 35'sd497837829;
            5'd2:  atan_q30 = 35'sd263043836;
            5'd3:  atan_q30 = 35'sd133525158;
            5'd4:  atan_q30 = 35'sd67021686;
            5'd5:  atan_q30 = 35'sd33543515;
            5'd6:  atan_q30 = 35'sd16775850;
            5'd7:  atan_q30 = 35'sd8388437;
            5'd8:  atan_q30 = 35'sd4194282;
            5'd9:  atan_q30 = 35'sd2097149;
            5'd10: atan_q30 = 35'sd1048575;
            5'd11: atan_q30 = 35'sd524287;
            5'd12: atan_q30 = 35'sd262143;
            5'd13: atan_q30 = 35'sd131071;
            5'd14: atan_q30 = 35'sd65535;
            5'd15: atan_q30 = 35'sd32767;
            5'd16: atan_q30 = 35'sd16383;
            5'd17: atan_q30 = 35'sd8191;
            5'd18: atan_q30 = 35'sd4095;
            5'd19: atan_q30 = 35'sd2047;
            5'd20: atan_q30 = 35'sd1023;
            5'd21: atan_q30 = 35'sd511;
            5'd22: atan_q30 = 35'sd255;
            5'd23: atan_q30 = 35'sd127;
            default: atan_q30 = 35'sd0;
        endcase
    endfunction

    // Rounds a Q.42 sum to Q.14 and clamps it to plus or minus one.
    function automatic t_q14 finish(input logic signed [47:0] v);
        logic signed [47:0] r;
        r = (v + 48'sd134217728) >>> 28;
        if (r > 48'sd16384) begin
            finish = 16'sd16384;
        end else if (r < -48'sd16384) begin
            finish = -16'sd16384;
        end else begin
            finish = r[15:0];
        end
    endfunction

endpackage

// File: sv/rotation_matrix_generator_core.sv
`timescale 1ns / 1ps
// Channel   | Ports                              | Transfer
// ----------+------------------------------------+------------------------------
// command   | i_func, i_angle_a/b/c, i_axis_x/y/z | start high while busy is low
// result    | o_r00 .. o_r22                     | o_valid high for one cycle
//
// A command transferred at one edge has its matrix taken once it has passed
// the CORDIC pipeline and the product, sum and clamp stages.
// One command may be issued every cycle; busy is always low, since the result
// side cannot stall and the pipeline never has to hold.
// The synchronous active-low reset clears the valid chain only; data registers
// carry no reset. The pipeline depth is set by the CORDIC: one stage per step.
module rotation_matrix_generator_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic signed [15:0] i_angle_a,
    input  logic signed [15:0] i_angle_b,
    input  logic signed [15:0] i_angle_c,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    output logic        o_valid,
    output logic signed [15:0] o_r00,
    output logic signed [15:0] o_r01,
    output logic signed [15:0] o_r02,
    output logic signed [15:0] o_r10,
    output logic signed [15:0] o_r11,
    output logic signed [15:0] o_r12,
    output logic signed [15:0] o_r20,
    output logic signed [15:0] o_r21,
    output logic signed [15:0] o_r22
);

    localparam int N = (CORDIC_STEPS < rmg_pkg::ATAN_LEN) ? CORDIC_STEPS : rmg_pkg::ATAN_LEN;
    localparam int CD = N + 2;   // CORDIC latency
    localparam int LAT = CD + 3; // total latency

    assign busy = 1'b0;

    logic r_v [LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= start;
            for (int k = 1; k < LAT; k++) r_v[k] <= r_v[k-1];
        end
    end
    assign o_valid = r_v[LAT-1];

    // Side data delayed to line up with the CORDIC outputs.
    logic        r_fd [CD];
    rmg_pkg::t_q14 r_xd [CD];
    rmg_pkg::t_q14 r_yd [CD];
    rmg_pkg::t_q14 r_zd [CD];
    always_ff @(posedge i_clk) begin
        r_fd[0] <= i_func;
        r_xd[0] <= i_axis_x;
        r_yd[0] <= i_axis_y;
        r_zd[0] <= i_axis_z;
        for (int k = 1; k < CD; k++) begin
            r_fd[k] <= r_fd[k-1];
            r_xd[k] <= r_xd[k-1];
            r_yd[k] <= r_yd[k-1];
            r_zd[k] <= r_zd[k-1];
        end
    end

    logic signed [15:0] ca, sa, cb, sb, cc, sc;
    rmg_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_a (.i_clk, .i_en(1'b1),
        .i_theta(i_angle_a), .o_cos(ca), .o_sin(sa));
    rmg_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_b (.i_clk, .i_en(1'b1),
        .i_theta(i_angle_b), .o_cos(cb), .o_sin(sb));
    rmg_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_c (.i_clk, .i_en(1'b1),
        .i_theta(i_angle_c), .o_cos(cc), .o_sin(sc));

    // Stage 1: first products. Axis mode forms xx,yy,zz,xy,xz,yz (Q.28)
    // and v; Euler mode forms the pairwise trig products.
    logic signed [33:0] r_p [9];
    logic signed [17:0] r_v1;
    logic signed [15:0] r_c1, r_s1, r_sp1, r_cy1, r_sy1;
    logic signed [15:0] r_x1, r_y1, r_z1;
    logic               r_f1;
    always_ff @(posedge i_clk) begin
        logic signed [15:0] x, y, z;
        x = r_xd[CD-1]; y = r_yd[CD-1]; z = r_zd[CD-1];
        r_f1 <= r_fd[CD-1];
        r_c1 <= ca; r_s1 <= sa; r_sp1 <= sb; r_cy1 <= ca; r_sy1 <= sa;
        r_x1 <= x; r_y1 <= y; r_z1 <= z;
        if (r_fd[CD-1] == rmg_pkg::FUNC_AXIS) begin
            r_v1 <= 18'(rmg_pkg::ONE_Q14) - 18'(ca);
            r_p[0] <= 34'(x * x); r_p[1] <= 34'(y * y); r_p[2] <= 34'(z * z);
            r_p[3] <= 34'(x * y); r_p[4] <= 34'(x * z); r_p[5] <= 34'(y * z);
            r_p[6] <= '0; r_p[7] <= '0; r_p[8] <= '0;
        end else begin
            r_p[0] <= 34'(cc * ca); r_p[1] <= 34'(sc * sb); r_p[2] <= 34'(sc * cb);
            r_p[3] <= 34'(cc * sa); r_p[4] <= 34'(sc * ca); r_p[5] <= 34'(cc * cb);
            r_p[6] <= 34'(sc * sa); r_p[7] <= 34'(cc * sb); r_p[8] <= 34'(cb * sa);
            r_v1 <= 18'(cb); // holds cp
        end
    end

    // Stage 2: second products at Q.42.
    logic signed [47:0] r_q [13];
    logic               r_f2;
    always_ff @(posedge i_clk) begin
        r_f2 <= r_f1;
        if (r_f1 == rmg_pkg::FUNC_AXIS) begin
            r_q[0] <= 48'(r_p[0] * r_v1);
            r_q[1] <= 48'(r_p[1] * r_v1);
            r_q[2] <= 48'(r_p[2] * r_v1);
            r_q[3] <= 48'(r_p[3] * r_v1);
            r_q[4] <= 48'(r_p[4] * r_v1);
            r_q[5] <= 48'(r_p[5] * r_v1);
            r_q[6] <= 48'(r_c1 * 32'sd268435456);
            r_q[7] <= 48'(r_z1 * r_s1) <<< 14;
            r_q[8] <= 48'(r_y1 * r_s1) <<< 14;
            r_q[9] <= 48'(r_x1 * r_s1) <<< 14;
        end else begin
            r_q[0] <= 48'(r_p[0]) <<< 14;               // cr*cy
            r_q[1] <= 48'(r_p[1] * r_sy1);              // sr*sp*sy
            r_q[2] <= -(48'(r_p[2]) <<< 14);            // -sr*cp
            r_q[3] <= 48'(r_p[3]) <<< 14;               // cr*sy
            r_q[4] <= 48'(r_p[1] * r_cy1);              // sr*sp*cy
            r_q[5] <= 48'(r_p[4]) <<< 14;               // sr*cy
            r_q[6] <= 48'(r_p[7] * r_sy1);              // cr*sp*sy
            r_q[7] <= 48'(r_p[5]) <<< 14;               // cr*cp
            r_q[8] <= 48'(r_p[6]) <<< 14;               // sr*sy
            r_q[9] <= 48'(r_p[7] * r_cy1);              // cr*sp*cy
            r_q[10] <= -(48'(r_p[8]) <<< 14);           // -cp*sy
            r_q[11] <= 48'(r_sp1 * 32'sd268435456);     // sp
            r_q[12] <= 48'(r_v1 * r_cy1) <<< 14;        // cp*cy
        end
    end

    // Stage 3: sums, rounding and clamping.
    always_ff @(posedge i_clk) begin
        if (r_f2 == rmg_pkg::FUNC_AXIS) begin
            o_r00 <= rmg_pkg::finish(r_q[0] + r_q[6]);
            o_r01 <= rmg_pkg::finish(r_q[3] + r_q[7]);
            o_r02 <= rmg_pkg::finish(r_q[4] - r_q[8]);
            o_r10 <= rmg_pkg::finish(r_q[3] - r_q[7]);
            o_r11 <= rmg_pkg::finish(r_q[1] + r_q[6]);
            o_r12 <= rmg_pkg::finish(r_q[5] + r_q[9]);
            o_r20 <= rmg_pkg::finish(r_q[4] + r_q[8]);
            o_r21 <= rmg_pkg::finish(r_q[5] - r_q[9]);
            o_r22 <= rmg_pkg::finish(r_q[2] + r_q[6]);
        end else begin
            o_r00 <= rmg_pkg::finish(r_q[0] - r_q[1]);
            o_r01 <= rmg_pkg::finish(r_q[2]);
            o_r02 <= rmg_pkg::finish(r_q[3] + r_q[4]);
            o_r10 <= rmg_pkg::finish(r_q[5] + r_q[6]);
            o_r11 <= rmg_pkg::finish(r_q[7]);
            o_r12 <= rmg_pkg::finish(r_q[8] - r_q[9]);
            o_r20 <= rmg_pkg::finish(r_q[10]);
            o_r21 <= rmg_pkg::finish(r_q[11]);
            o_r22 <= rmg_pkg::finish(r_q[12]);
        end
    end

endmodule

// File: sv/rmg_sincos.sv
`timescale 1ns / 1ps
module rmg_sincos #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic signed [15:0] i_theta,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin
);

    localparam int N = (CORDIC_STEPS < rmg_pkg::ATAN_LEN) ? CORDIC_STEPS : rmg_pkg::ATAN_LEN;

    rmg_pkg::t_cval r_x [N+1];
    rmg_pkg::t_cval r_y [N+1];
    rmg_pkg::t_aval r_a [N+1];
    logic           r_neg [N+1];
    rmg_pkg::t_aval n_a0;
    logic           n_neg0;

    always_comb begin
        rmg_pkg::t_aval a;
        a = rmg_pkg::t_aval'(i_theta) <<< 18;
        n_neg0 = 1'b0;
        if (a > rmg_pkg::PI_Q30) a = a - rmg_pkg::TWO_PI_Q30;
        if (a < -rmg_pkg::PI_Q30) a = a + rmg_pkg::TWO_PI_Q30;
        if (a > rmg_pkg::HALF_PI_Q30) begin
            a = rmg_pkg::PI_Q30 - a;
            n_neg0 = 1'b1;
        end else if (a < -rmg_pkg::HALF_PI_Q30) begin
            a = -rmg_pkg::PI_Q30 - a;
            n_neg0 = 1'b1;
        end
        n_a0 = a;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= rmg_pkg::GAIN_Q30;
            r_y[0]   <= '0;
            r_a[0]   <= n_a0;
            r_neg[0] <= n_neg0;
        end
    end

    // One micro-rotation per pipeline stage.
    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_a[i][rmg_pkg::AW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] - rmg_pkg::atan_q30(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] + rmg_pkg::atan_q30(5'(i));
                end
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        rmg_pkg::t_cval xf;
        if (i_en) begin
            xf = r_neg[N] ? -r_x[N] : r_x[N];
            o_cos <= 16'((xf + 33'sd32768) >>> 16);
            o_sin <= 16'((r_y[N] + 33'sd32768) >>> 16);
        end
    end

endmodule

// File: verif/rotation_matrix_checker.sv
`timescale 1ns / 1ps
module rotation_matrix_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_func,
    input  logic signed [15:0] i_angle_a,
    input  logic signed [15:0] i_angle_b,
    input  logic signed [15:0] i_angle_c,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    input  logic        i_valid,
    input  rmg_pkg::t_q14 i_r [9],
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        rmg_pkg::t_q14 m [9];
    } t_matrix;

    t_matrix matrix_queue [$];
    int fail_total = 0;

    localparam longint ATAN_TBL [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

    string entry_names [9] = '{"r00", "r01", "r02", "r10", "r11", "r12",
                               "r20", "r21", "r22"};

    // Arithmetic right shift of a signed 64-bit value rounds toward minus infinity.
    function automatic void sincos(input longint theta, output longint cq,
                                   output longint sq);
        longint a, x, y, nx, dx, dy;
        bit flip;
        a = theta * 262144;
        x = 652032874;
        y = 0;
        flip = 0;
        if (a > 64'sd3373259426) a -= 64'sd6746518852;
        if (a < -64'sd3373259426) a += 64'sd6746518852;
        if (a > 64'sd1686629713) begin
            a = 64'sd3373259426 - a;
            flip = 1;
        end else if (a < -64'sd1686629713) begin
            a = -64'sd3373259426 - a;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
                nx = x - dx;
                y = y + dy;
                a -= ATAN_TBL[i];
            end else begin
                nx = x + dx;
                y = y - dy;
                a += ATAN_TBL[i];
            end
            x = nx;
        end
        if (flip) x = -x;
        cq = (x + 32768) >>> 16;
        sq = (y + 32768) >>> 16;
    endfunction

    function automatic rmg_pkg::t_q14 round_clamp(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 27)) >>> 28;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return rmg_pkg::t_q14'(r);
    endfunction

    function automatic t_matrix build_matrix(input logic f, input longint a,
                                             input longint b, input longint c_in,
                                             input longint x, input longint y,
                                             input longint z);
        t_matrix res;
        longint c, s, v, cy, sy, cp, sp, cr, sr;
        longint k;
        k = 16384;
        if (f == rmg_pkg::FUNC_AXIS) begin
            sincos(a, c, s);
            v = k - c;
            res.m[0] = round_clamp(x * x * v + c * k * k);
            res.m[1] = round_clamp(x * y * v + z * s * k);
            res.m[2] = round_clamp(x * z * v - y * s * k);
            res.m[3] = round_clamp(x * y * v - z * s * k);
            res.m[4] = round_clamp(y * y * v + c * k * k);
            res.m[5] = round_clamp(y * z * v + x * s * k);
            res.m[6] = round_clamp(x * z * v + y * s * k);
            res.m[7] = round_clamp(y * z * v - x * s * k);
            res.m[8] = round_clamp(z * z * v + c * k * k);
        end else begin
            sincos(a, cy, sy);
            sincos(b, cp, sp);
            sincos(c_in, cr, sr);
            res.m[0] = round_clamp(cr * cy * k - sr * sp * sy);
            res.m[1] = round_clamp(-sr * cp * k);
            res.m[2] = round_clamp(cr * sy * k + sr * sp * cy);
            res.m[3] = round_clamp(sr * cy * k + cr * sp * sy);
            res.m[4] = round_clamp(cr * cp * k);
            res.m[5] = round_clamp(sr * sy * k - cr * sp * cy);
            res.m[6] = round_clamp(-cp * sy * k);
            res.m[7] = round_clamp(sp * k * k);
            res.m[8] = round_clamp(cp * cy * k);
        end
        return res;
    endfunction

    assign o_pending = matrix_queue.size();
    assign o_fail_count = fail_total;

    always @(posedge i_clk) begin
        t_matrix want;
        int bad;
        bad = 0;
        if (i_rst_n && i_start && !i_busy) begin
            matrix_queue.push_back(build_matrix(i_func, i_angle_a, i_angle_b,
                                                i_angle_c, i_axis_x, i_axis_y,
                                                i_axis_z));
        end
        if (i_rst_n && i_valid) begin
            if (matrix_queue.size() == 0) begin
                $error("matrix transfer with nothing expected");
                bad++;
            end else begin
                want = matrix_queue.pop_front();
                for (int e = 0; e < 9; e++) begin
                    if (i_r[e] !== want.m[e]) begin
                        $error("%s expected %0d got %0d", entry_names[e],
                               want.m[e], i_r[e]);
                        bad++;
                    end
                end
            end
        end
        if (bad != 0) fail_total <= fail_total + bad;
    end

endmodule

// File: verif/rotation_matrix_generator_core_tb.sv
`timescale 1ns / 1ps
module rotation_matrix_generator_core_tb;

    localparam int STEPS = 16;
    // Result is taken after the CORDIC pipeline and the product and sum stages.
    localparam int LATENCY = STEPS + 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1500;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_func = 1'b0;
    logic signed [15:0] i_angle_a = '0;
    logic signed [15:0] i_angle_b = '0;
    logic signed [15:0] i_angle_c = '0;
    logic signed [15:0] i_axis_x = '0;
    logic signed [15:0] i_axis_y = '0;
    logic signed [15:0] i_axis_z = '0;
    logic o_valid;
    rmg_pkg::t_q14 r_bus [9];
    int fail_count;
    int pending;
    int cycle_count = 0;

    // Each half period is 4 ns, giving an 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    rotation_matrix_generator_core #(.CORDIC_STEPS(STEPS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_angle_a(i_angle_a), .i_angle_b(i_angle_b),
        .i_angle_c(i_angle_c), .i_axis_x(i_axis_x), .i_axis_y(i_axis_y),
        .i_axis_z(i_axis_z), .o_valid(o_valid),
        .o_r00(r_bus[0]), .o_r01(r_bus[1]), .o_r02(r_bus[2]),
        .o_r10(r_bus[3]), .o_r11(r_bus[4]), .o_r12(r_bus[5]),
        .o_r20(r_bus[6]), .o_r21(r_bus[7]), .o_r22(r_bus[8])
    );

    // The checker sees the same signals as the block and keeps its own
    // queue of predicted matrices.
    rotation_matrix_checker #(.CORDIC_STEPS(STEPS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_func(i_func), .i_angle_a(i_angle_a), .i_angle_b(i_angle_b),
        .i_angle_c(i_angle_c), .i_axis_x(i_axis_x), .i_axis_y(i_axis_y),
        .i_axis_z(i_axis_z), .i_valid(o_valid), .i_r(r_bus),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The watchdog ends a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Picks an axis component: mostly in range, with the extremes and
    // occasionally any 16-bit value so every bit toggles and saturation occurs.
    function automatic logic signed [15:0] pick_axis();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'sd16384;
        if (sel == 1) return -16'sd16384;
        if (sel == 2) return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // Angles favor the principal range but cover the whole field, so the
    // wrap-around and quadrant folding of the sine and cosine both get exercised.
    function automatic logic signed [15:0] pick_angle();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 16'h7FFF;
        if (sel == 1) return 16'h8000;
        if (sel < 5) return 16'($urandom);
        return 16'($signed($urandom_range(0, 25736)) - 12868);
    endfunction

    // Drives one command and holds it until the transfer edge. A gap only
    // lowers start when it is actually taken, so start is never lowered and
    // raised within one step.
    task automatic issue(input logic f, input logic signed [15:0] a,
                         input logic signed [15:0] b, input logic signed [15:0] c,
                         input logic signed [15:0] x, input logic signed [15:0] y,
                         input logic signed [15:0] z, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= f;
        i_angle_a <= a;
        i_angle_b <= b;
        i_angle_c <= c;
        i_axis_x <= x;
        i_axis_y <= y;
        i_axis_z <= z;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        int idle_pct;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed commands: zero angle, both ends of the angle field,
        // the quarter and half turn, unit axes and the saturation case of
        // an out-of-range axis, plus Euler commands with each angle alone.
        issue(rmg_pkg::FUNC_AXIS, 0, 0, 0, 16384, 0, 0, 0);
        issue(rmg_pkg::FUNC_AXIS, 16'sd6434, 0, 0, 0, 16384, 0, 0);
        issue(rmg_pkg::FUNC_AXIS, 16'sd12868, 0, 0, 0, 0, 16384, 0);
        issue(rmg_pkg::FUNC_AXIS, -16'sd12868, 16'h7FFF, 16'h8000, 0, 0, -16384, 0);
        issue(rmg_pkg::FUNC_AXIS, 16'h7FFF, 0, 0, 9459, 9459, 9459, 0);
        issue(rmg_pkg::FUNC_AXIS, 16'h8000, 0, 0, -9459, 9459, -9459, 0);
        issue(rmg_pkg::FUNC_AXIS, 16'sd3217, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
        issue(rmg_pkg::FUNC_AXIS, -16'sd3217, 0, 0, 16'h8000, 16'h8000, 16'h8000, 0);
        issue(rmg_pkg::FUNC_AXIS, 16'sd12869, 0, 0, 16'hFFFF, 16'h5555, 16'hAAAA, 0);
        issue(rmg_pkg::FUNC_EULER, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h1234, 0);
        issue(rmg_pkg::FUNC_EULER, 16'sd6434, 0, 0, 0, 0, 0, 0);
        issue(rmg_pkg::FUNC_EULER, 0, 16'sd6434, 0, 0, 0, 0, 0);
        issue(rmg_pkg::FUNC_EULER, 0, 0, 16'sd6434, 0, 0, 0, 0);
        issue(rmg_pkg::FUNC_EULER, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0);
        issue(rmg_pkg::FUNC_EULER, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0);
        issue(rmg_pkg::FUNC_EULER, 16'sd12868, -16'sd12868, 16'sd3217, 0, 0, 0, 0);

        // Random commands in four phases: no idling, heavy sender idling,
        // a phase aimed at the result side (which cannot stall, so the
        // sender runs freely), and light sender idling.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n * 4) / RANDOM_ITEMS)
                0: idle_pct = 0;
                1: idle_pct = 81;
                2: idle_pct = 0;
                default: idle_pct = 15;
            endcase
            issue(1'($urandom), pick_angle(), pick_angle(), pick_angle(),
                  pick_axis(), pick_axis(), pick_axis(), idle_pct);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/rmg_pkg.sv
sv/rmg_sincos.sv
sv/rotation_matrix_generator_core.sv
verif/rotation_matrix_checker.sv
verif/rotation_matrix_generator_core_tb.sv
